FILE: src/http_request_header_parser_assert.svh
// Assertion macros for the HTTP request header parser.
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
// same-cycle implication
`define HRP_ASSERT_NOW(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define HRP_ASSERT_NEXT(label, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: src/hrp_pkg.sv
// Shared types, codes and byte classes for the HTTP request header parser.
`default_nettype none
package hrp_pkg;

	typedef enum logic [4:0] {
		PH_METHOD, PH_URI, PH_H, PH_T1, PH_T2, PH_P, PH_SLASH, PH_MAJ0, PH_MAJ,
		PH_MIN0, PH_MIN, PH_RL_LF, PH_LINE, PH_NAME, PH_CONT, PH_COLSP, PH_VALUE,
		PH_END_LF, PH_VAL_LF, PH_BODY, PH_DONE, PH_FAIL
	} hrp_phase_t;

	typedef enum logic [1:0] {
		ST_MORE = 2'd0, ST_DONE = 2'd1, ST_BAD = 2'd2, ST_IDLE = 2'd3
	} hrp_status_t;

	typedef enum logic [2:0] {
		KIND_OTHER = 3'd0, KIND_METHOD = 3'd1, KIND_URI = 3'd2,
		KIND_NAME = 3'd3, KIND_VALUE = 3'd4, KIND_BODY = 3'd5
	} hrp_kind_t;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [3:0] CL_NAME_LEN = 4'd14;
	localparam int QDEPTH = 4;

	// classified byte, front to back
	typedef struct packed {
		logic       begin_req;
		logic [7:0] data;
		logic [7:0] lower;
		logic       tok;
		logic       ctl;
		logic       dig;
	} hrp_item_t;

	typedef struct packed {
		hrp_status_t status;
		hrp_kind_t   field_kind;
		logic [7:0]  out_byte;
		logic [5:0]  header_index;
		logic [15:0] version_major;
		logic [15:0] version_minor;
		logic [31:0] body_length;
	} hrp_result_t;

	function automatic logic is_ctl(input logic [7:0] c);
		return (c <= 8'd31) || (c == 8'd127);
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		logic r;
		unique case (c)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
			8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] cl_name(input logic [3:0] pos);
		logic [7:0] r;
		unique case (pos)
			4'd0: r = "c";  4'd1: r = "o";  4'd2: r = "n";  4'd3: r = "t";
			4'd4: r = "e";  4'd5: r = "n";  4'd6: r = "t";  4'd7: r = "-";
			4'd8: r = "l";  4'd9: r = "e";  4'd10: r = "n"; 4'd11: r = "g";
			4'd12: r = "t"; 4'd13: r = "h";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/hrp_front.sv
// Front stage: accepts input bytes and registers their character classes.
`default_nettype none
module hrp_front import hrp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic      begin_req,
	input  wire logic [7:0] data,
	output logic           item_valid,
	input  wire logic      item_ready,
	output hrp_item_t      item
);
	logic      valid_s1;
	hrp_item_t item_s1;

	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.begin_req <= begin_req;
			item_s1.data      <= data;
			item_s1.lower     <= to_lower(data);
			item_s1.ctl       <= is_ctl(data);
			item_s1.tok       <= !data[7] && !is_ctl(data) && !is_sep(data);
			item_s1.dig       <= (data >= 8'h30) && (data <= 8'h39);
		end
	end
endmodule
`default_nettype wire

FILE: src/hrp_queue.sv
// Short queue of classified bytes between front and back.
`default_nettype none
module hrp_queue import hrp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  hrp_item_t push_item,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output hrp_item_t pop_item
);
	localparam int PW = $clog2(QDEPTH);
	hrp_item_t         mem_q [QDEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [PW:0]       cnt_q;
	logic              push, pop;

	assign push_ready = (cnt_q != (PW+1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end
endmodule
`default_nettype wire

FILE: src/hrp_back.sv
// Back stage: request grammar state machine and registered result.
`default_nettype none
module hrp_back import hrp_pkg::*; #(
	parameter int MAX_HEADERS = 32,
	parameter int LENGTH_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_ready,
	input  hrp_item_t item,
	output logic      res_valid,
	input  wire logic res_ready,
	output hrp_result_t res
);
	localparam int HCW = $clog2(MAX_HEADERS + 1);
	localparam int LB  = LENGTH_BITS;

	hrp_phase_t     phase_q, b_phase, n_phase, ph;
	logic           fne_q, b_fne, n_fne;
	logic [15:0]    maj_q, b_maj, n_maj, min_q, b_min, n_min;
	logic [HCW-1:0] hc_q, b_hc, n_hc, hidx;
	logic [3:0]     pos_q, b_pos, n_pos;
	logic           nil_q, b_nil, n_nil;
	logic [LB-1:0]  acc_q, b_acc, n_acc, fin_q, b_fin, n_fin, bc_q, b_bc, n_bc;
	logic           bad_q, b_bad, n_bad;
	logic           fh_bad;
	logic [LB-1:0]  fh_fin;
	logic [LB+3:0]  acc_x10;
	logic [19:0]    ver_x10;
	logic [LB-1:0]  bc_inc;
	hrp_status_t    st;
	hrp_kind_t      kind;
	logic           hdr, take, out_valid_q;
	logic [7:0]     c;
	hrp_result_t    res_q;

	assign take       = item_valid && item_ready;
	assign item_ready = !out_valid_q || res_ready;
	assign res_valid  = out_valid_q;
	assign res        = res_q;
	assign c          = item.data;

	always_comb begin
		if (item.begin_req) begin
			b_phase = PH_METHOD; b_fne = 1'b0; b_maj = '0; b_min = '0; b_hc = '0;
			b_pos = '0; b_nil = 1'b0; b_acc = '0; b_bad = 1'b0; b_fin = '0; b_bc = '0;
		end else begin
			b_phase = phase_q; b_fne = fne_q; b_maj = maj_q; b_min = min_q; b_hc = hc_q;
			b_pos = pos_q; b_nil = nil_q; b_acc = acc_q; b_bad = bad_q; b_fin = fin_q;
			b_bc = bc_q;
		end
	end

	// end-of-header bookkeeping for a Content-Length header
	assign fh_bad  = b_bad || ((b_hc != '0) && b_nil && !b_fne);
	assign fh_fin  = ((b_hc != '0) && b_nil && b_fne) ? b_acc : b_fin;
	assign acc_x10 = ({4'b0, b_acc} << 3) + ({4'b0, b_acc} << 1)
		+ (LB+4)'(c - CH_ZERO);
	assign bc_inc  = b_bc + 1'b1;

	always_comb begin
		ver_x10 = '0;
		if (b_phase == PH_MAJ0 || b_phase == PH_MAJ) begin
			ver_x10 = ({4'b0, b_maj} << 3) + ({4'b0, b_maj} << 1) + 20'(c - CH_ZERO);
		end else begin
			ver_x10 = ({4'b0, b_min} << 3) + ({4'b0, b_min} << 1) + 20'(c - CH_ZERO);
		end
	end

	always_comb begin
		ph = b_phase; n_fne = b_fne; n_maj = b_maj; n_min = b_min; n_hc = b_hc;
		n_pos = b_pos; n_nil = b_nil; n_acc = b_acc; n_bad = b_bad; n_fin = b_fin;
		n_bc = b_bc; st = ST_MORE; kind = KIND_OTHER; hdr = 1'b0;
		unique case (b_phase)
			PH_METHOD: begin
				if (item.tok) begin
					kind = KIND_METHOD; n_fne = 1'b1;
				end else if (b_fne && c == CH_SP) begin
					n_fne = 1'b0; ph = PH_URI;
				end else ph = PH_FAIL;
			end
			PH_URI: begin
				if (!item.ctl && c != CH_SP) begin
					kind = KIND_URI; n_fne = 1'b1;
				end else if (b_fne && c == CH_SP) begin
					n_fne = 1'b0; ph = PH_H;
				end else ph = PH_FAIL;
			end
			PH_H:     ph = (c == CH_H) ? PH_T1 : PH_FAIL;
			PH_T1:    ph = (c == CH_T) ? PH_T2 : PH_FAIL;
			PH_T2:    ph = (c == CH_T) ? PH_P : PH_FAIL;
			PH_P:     ph = (c == CH_P) ? PH_SLASH : PH_FAIL;
			PH_SLASH: ph = (c == CH_SLASH) ? PH_MAJ0 : PH_FAIL;
			PH_MAJ0, PH_MAJ: begin
				if (item.dig) begin
					n_maj = (ver_x10[19:16] != '0) ? 16'hFFFF : ver_x10[15:0];
					ph = PH_MAJ;
				end else if (b_phase == PH_MAJ && c == CH_DOT) ph = PH_MIN0;
				else ph = PH_FAIL;
			end
			PH_MIN0, PH_MIN: begin
				if (item.dig) begin
					n_min = (ver_x10[19:16] != '0) ? 16'hFFFF : ver_x10[15:0];
					ph = PH_MIN;
				end else if (b_phase == PH_MIN && c == CH_CR) ph = PH_RL_LF;
				else ph = PH_FAIL;
			end
			PH_RL_LF, PH_VAL_LF: begin
				hdr = (b_phase == PH_VAL_LF);
				ph = (c == CH_LF) ? PH_LINE : PH_FAIL;
			end
			PH_LINE: begin
				if (item.tok) begin
					n_bad = fh_bad; n_fin = fh_fin; n_acc = '0;
					n_nil = 1'b0; n_pos = '0;
					if (b_hc >= HCW'(MAX_HEADERS)) begin
						ph = PH_FAIL;
					end else begin
						n_hc = b_hc + 1'b1;
						if (item.lower == cl_name(4'd0)) begin
							n_nil = 1'b1; n_pos = 4'd1;
						end
						kind = KIND_NAME; hdr = 1'b1; ph = PH_NAME;
					end
				end else if (c == CH_SP || c == CH_TAB) begin
					if (b_hc == '0) ph = PH_FAIL;
					else begin
						hdr = 1'b1; ph = PH_CONT;
					end
				end else if (c == CH_CR) ph = PH_END_LF;
				else ph = PH_FAIL;
			end
			PH_NAME: begin
				hdr = 1'b1;
				if (item.tok) begin
					kind = KIND_NAME;
					if (b_nil) begin
						if (b_pos < CL_NAME_LEN && item.lower == cl_name(b_pos))
							n_pos = b_pos + 1'b1;
						else n_nil = 1'b0;
					end
				end else if (c == CH_COLON) begin
					if (b_pos != CL_NAME_LEN) n_nil = 1'b0;
					ph = PH_COLSP;
				end else ph = PH_FAIL;
			end
			PH_COLSP: begin
				hdr = 1'b1;
				if (c == CH_SP) begin
					n_fne = 1'b0; n_acc = '0; ph = PH_VALUE;
				end else ph = PH_FAIL;
			end
			PH_CONT, PH_VALUE: begin
				hdr = 1'b1;
				if (b_phase == PH_CONT && (c == CH_SP || c == CH_TAB)) begin
					ph = b_phase;
				end else if (c >= 8'd32 && c <= 8'd126) begin
					n_fne = 1'b1; kind = KIND_VALUE; ph = PH_VALUE;
					if (b_nil) begin
						if (item.dig && acc_x10[LB+3:LB] == '0) n_acc = acc_x10[LB-1:0];
						else n_bad = 1'b1;
					end
				end else if (c == CH_CR) ph = PH_VAL_LF;
				else ph = PH_FAIL;
			end
			PH_END_LF: begin
				if (c != CH_LF) ph = PH_FAIL;
				else begin
					n_bad = fh_bad; n_fin = fh_fin; n_acc = '0;
					n_nil = 1'b0; n_pos = '0;
					if (fh_bad) ph = PH_FAIL;
					else if (fh_fin == '0) begin
						ph = PH_DONE; st = ST_DONE;
					end else ph = PH_BODY;
				end
			end
			PH_BODY: begin
				kind = KIND_BODY; n_bc = bc_inc;
				if (bc_inc >= b_fin) begin
					ph = PH_DONE; st = ST_DONE;
				end
			end
			default: st = ST_IDLE;
		endcase
		if (ph == PH_FAIL && st != ST_IDLE) begin
			st = ST_BAD; kind = KIND_OTHER;
		end
		if (st != ST_IDLE) n_phase = ph;
		else n_phase = (ph == PH_DONE) ? PH_DONE : PH_FAIL;
		hidx = (hdr && n_hc != '0) ? n_hc - 1'b1 : n_hc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q <= PH_METHOD; fne_q <= 1'b0; maj_q <= '0; min_q <= '0; hc_q <= '0;
			pos_q <= '0; nil_q <= 1'b0; acc_q <= '0; bad_q <= 1'b0; fin_q <= '0;
			bc_q <= '0;
		end else begin
			if (item_ready) out_valid_q <= item_valid;
			if (take) begin
				phase_q <= n_phase; fne_q <= n_fne; maj_q <= n_maj; min_q <= n_min;
				hc_q <= n_hc; pos_q <= n_pos; nil_q <= n_nil; acc_q <= n_acc;
				bad_q <= n_bad; fin_q <= n_fin; bc_q <= n_bc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.status        <= st;
			res_q.field_kind    <= kind;
			res_q.out_byte      <= c;
			res_q.header_index  <= 6'(hidx);
			res_q.version_major <= n_maj;
			res_q.version_minor <= n_min;
			res_q.body_length   <= (n_phase == PH_BODY || n_phase == PH_DONE)
				? 32'(n_fin) : 32'd0;
		end
	end

`include "http_request_header_parser_assert.svh"
	`HRP_ASSERT_NEXT(a_done_phase, arst_n, take && st == ST_DONE, phase_q == PH_DONE, "complete without done phase")
	`HRP_ASSERT_NEXT(a_bad_phase, arst_n, take && st == ST_BAD, phase_q == PH_FAIL, "malformed without fail phase")
	`HRP_ASSERT_NOW(a_body_len, arst_n, phase_q == PH_BODY, fin_q != '0, "body phase with zero length")
endmodule
`default_nettype wire

FILE: src/http_request_header_parser.sv
// Top level of the HTTP request header parser.
// Parses an HTTP request one byte per clock while the result output is not
// stalled, and returns one result per byte: status, byte role, header index,
// versions and body length. Each result passes the classify register, the
// queue and the result register in that order. Set s_tuser high on the first
// byte of each request.
`default_nettype none
module http_request_header_parser import hrp_pkg::*; #(
	parameter int MAX_HEADERS = 32,
	parameter int LENGTH_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // in_byte
	input  wire logic [0:0]  s_tuser,  // begin_request
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,  // status, out_byte, header_index,
	                                   // version_major, version_minor, body_length
	output logic [2:0]       m_tuser   // field_kind
);
	logic        f_valid, f_ready, q_valid, q_ready;
	hrp_item_t   f_item, q_item;
	hrp_result_t r;

	hrp_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.begin_req(s_tuser[0]), .data(s_tdata),
		.item_valid(f_valid), .item_ready(f_ready), .item(f_item)
	);

	hrp_queue u_queue (
		.clk, .arst_n, .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
		.pop_valid(q_valid), .pop_ready(q_ready), .pop_item(q_item)
	);

	hrp_back #(.MAX_HEADERS(MAX_HEADERS), .LENGTH_BITS(LENGTH_BITS)) u_back (
		.clk, .arst_n, .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(r)
	);

	assign m_tdata = {r.body_length, r.version_minor, r.version_major,
		r.header_index, r.out_byte, r.status};
	assign m_tuser = r.field_kind;
endmodule
`default_nettype wire

FILE: tb/hrp_checker.sv
// Checker for the HTTP request header parser: predicts each result and compares it.
module hrp_checker import hrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,
	input  logic [2:0]  m_tuser,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_HDR = 32;
	localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF;

	typedef struct {
		hrp_status_t status;
		hrp_kind_t   kind;
		logic [7:0]  data;
		logic [5:0]  hidx;
		logic [15:0] major;
		logic [15:0] minor;
		logic [31:0] blen;
	} parse_result_t;

	parse_result_t result_q[$];

	hrp_phase_t  phase;
	logic        seen_byte;
	logic [15:0] major_v, minor_v;
	int          hdr_count;
	int          match_pos;
	logic        name_cl;
	logic [63:0] len_acc, len_final, body_cnt;
	logic        len_bad;

	function automatic logic ctl_byte(input logic [7:0] c);
		return c < 8'd32 || c == 8'd127;
	endfunction

	function automatic logic tok_byte(input logic [7:0] c);
		string seps;
		seps = "()<>@,;:\\\"/[]?={} \t";
		if (c > 8'd127 || ctl_byte(c))
			return 1'b0;
		for (int i = 0; i < seps.len(); i++)
			if (seps[i] == c)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [15:0] ver_step(input logic [15:0] acc, input logic [7:0] c);
		int v;
		v = acc * 10 + (c - "0");
		return v > 65535 ? 16'hFFFF : v[15:0];
	endfunction

	task automatic clear_state();
		phase = PH_METHOD;
		seen_byte = 1'b0;
		major_v = '0;
		minor_v = '0;
		hdr_count = 0;
		match_pos = 0;
		name_cl = 1'b0;
		len_acc = '0;
		len_bad = 1'b0;
		len_final = '0;
		body_cnt = '0;
	endtask

	task automatic track_name(input logic [7:0] c);
		string cl;
		logic [7:0] lc;
		cl = "content-length";
		lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		if (name_cl) begin
			if (match_pos < 14 && lc == cl[match_pos])
				match_pos++;
			else
				name_cl = 1'b0;
		end
	endtask

	task automatic close_header();
		if (hdr_count > 0 && name_cl) begin
			if (!seen_byte)
				len_bad = 1'b1;
			else
				len_final = len_acc;
		end
		len_acc = '0;
		name_cl = 1'b0;
		match_pos = 0;
	endtask

	task automatic parse_byte(input logic beg, input logic [7:0] c, output parse_result_t r);
		hrp_phase_t  ph;
		hrp_status_t st;
		hrp_kind_t   kind;
		logic        hdr;
		logic [63:0] d;
		if (beg)
			clear_state();
		ph = phase;
		st = ST_MORE;
		kind = KIND_OTHER;
		hdr = 1'b0;
		case (ph)
			PH_METHOD:
				if (tok_byte(c)) begin
					kind = KIND_METHOD;
					seen_byte = 1'b1;
				end else if (seen_byte && c == CH_SP) begin
					seen_byte = 1'b0;
					ph = PH_URI;
				end else ph = PH_FAIL;
			PH_URI:
				if (!ctl_byte(c) && c != CH_SP) begin
					kind = KIND_URI;
					seen_byte = 1'b1;
				end else if (seen_byte && c == CH_SP) begin
					seen_byte = 1'b0;
					ph = PH_H;
				end else ph = PH_FAIL;
			PH_H:     ph = (c == "H") ? PH_T1 : PH_FAIL;
			PH_T1:    ph = (c == "T") ? PH_T2 : PH_FAIL;
			PH_T2:    ph = (c == "T") ? PH_P : PH_FAIL;
			PH_P:     ph = (c == "P") ? PH_SLASH : PH_FAIL;
			PH_SLASH: ph = (c == "/") ? PH_MAJ0 : PH_FAIL;
			PH_MAJ0, PH_MAJ:
				if (digit(c)) begin
					major_v = ver_step(major_v, c);
					ph = PH_MAJ;
				end else if (ph == PH_MAJ && c == CH_DOT) ph = PH_MIN0;
				else ph = PH_FAIL;
			PH_MIN0, PH_MIN:
				if (digit(c)) begin
					minor_v = ver_step(minor_v, c);
					ph = PH_MIN;
				end else if (ph == PH_MIN && c == CH_CR) ph = PH_RL_LF;
				else ph = PH_FAIL;
			PH_RL_LF, PH_VAL_LF: begin
				hdr = (ph == PH_VAL_LF);
				ph = (c == CH_LF) ? PH_LINE : PH_FAIL;
			end
			PH_LINE:
				if (tok_byte(c)) begin
					close_header();
					if (hdr_count >= MAX_HDR) begin
						ph = PH_FAIL;
					end else begin
						hdr_count++;
						name_cl = 1'b1;
						track_name(c);
						kind = KIND_NAME;
						hdr = 1'b1;
						ph = PH_NAME;
					end
				end else if (c == CH_SP || c == CH_TAB) begin
					if (hdr_count == 0) begin
						ph = PH_FAIL;
					end else begin
						hdr = 1'b1;
						ph = PH_CONT;
					end
				end else if (c == CH_CR) ph = PH_END_LF;
				else ph = PH_FAIL;
			PH_NAME: begin
				hdr = 1'b1;
				if (tok_byte(c)) begin
					track_name(c);
					kind = KIND_NAME;
				end else if (c == CH_COLON) begin
					if (match_pos != 14)
						name_cl = 1'b0;
					ph = PH_COLSP;
				end else ph = PH_FAIL;
			end
			PH_COLSP: begin
				hdr = 1'b1;
				if (c == CH_SP) begin
					seen_byte = 1'b0;
					len_acc = '0;
					ph = PH_VALUE;
				end else ph = PH_FAIL;
			end
			PH_CONT, PH_VALUE: begin
				hdr = 1'b1;
				if (!(ph == PH_CONT && (c == CH_SP || c == CH_TAB))) begin
					if (c >= 8'd32 && c <= 8'd126) begin
						seen_byte = 1'b1;
						if (name_cl) begin
							if (digit(c)) begin
								d = c - "0";
								if (len_acc > (LEN_MAX - d) / 10)
									len_bad = 1'b1;
								else
									len_acc = len_acc * 10 + d;
							end else len_bad = 1'b1;
						end
						kind = KIND_VALUE;
						ph = PH_VALUE;
					end else if (c == CH_CR) ph = PH_VAL_LF;
					else ph = PH_FAIL;
				end
			end
			PH_END_LF:
				if (c != CH_LF) begin
					ph = PH_FAIL;
				end else begin
					close_header();
					if (len_bad) ph = PH_FAIL;
					else if (len_final == 0) begin
						ph = PH_DONE;
						st = ST_DONE;
					end else ph = PH_BODY;
				end
			PH_BODY: begin
				kind = KIND_BODY;
				body_cnt++;
				if (body_cnt >= len_final) begin
					ph = PH_DONE;
					st = ST_DONE;
				end
			end
			default: st = ST_IDLE;
		endcase
		if (ph == PH_FAIL && phase != PH_FAIL && st != ST_IDLE) begin
			st = ST_BAD;
			kind = KIND_OTHER;
		end
		if (st != ST_IDLE)
			phase = ph;
		else
			phase = (ph == PH_DONE) ? PH_DONE : PH_FAIL;
		r.status = st;
		r.kind = kind;
		r.data = c;
		r.hidx = 6'((hdr && hdr_count > 0) ? hdr_count - 1 : hdr_count);
		r.major = major_v;
		r.minor = minor_v;
		r.blen = (phase == PH_BODY || phase == PH_DONE) ? len_final[31:0] : 32'd0;
	endtask

	initial clear_state();

	always @(posedge clk or negedge arst_n) begin
		parse_result_t r, e;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tuser[0], s_tdata, r);
				result_q = {result_q, r};
			end
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: result with nothing expected: %h", $realtime, m_tdata);
					errors <= errors + 1;
				end else begin
					e = result_q.pop_front();
					if (m_tdata[1:0] !== e.status || m_tuser !== e.kind ||
					    m_tdata[9:2] !== e.data || m_tdata[15:10] !== e.hidx ||
					    m_tdata[31:16] !== e.major || m_tdata[47:32] !== e.minor ||
					    m_tdata[79:48] !== e.blen) begin
						if (errors < 10)
							$display({"%0t: mismatch exp st=%0d kind=%0d byte=%h hidx=%0d ",
								"maj=%0d min=%0d len=%0d | got st=%0d kind=%0d byte=%h ",
								"hidx=%0d maj=%0d min=%0d len=%0d"}, $realtime,
								e.status, e.kind, e.data, e.hidx, e.major, e.minor, e.blen,
								m_tdata[1:0], m_tuser, m_tdata[9:2], m_tdata[15:10],
								m_tdata[31:16], m_tdata[47:32], m_tdata[79:48]);
						errors <= errors + 1;
					end
				end
			end
			pending <= result_q.size();
		end
	end
endmodule

FILE: tb/tb.sv
// Testbench top for the HTTP request header parser: stimulus, handshakes and verdict.
module tb import hrp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ITEMS = 1300;
	localparam int STALL_LIMIT = 3000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = 0;
	logic [0:0]  s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [79:0] m_tdata;
	logic [2:0]  m_tuser;
	int          errors, pending;

	int   send_idle = 9, recv_idle = 75;
	int   bytes_sent = 0;
	logic hold_go = 0;
	int   hold_left = 0;
	int   quiet = 0;
	logic [7:0] req_q[$];

	always #6 clk = ~clk;

	http_request_header_parser u_top (.*);

	hrp_checker u_chk (.*);

	always @(posedge clk) begin
		if (hold_go && hold_left == 0 && bytes_sent < N_ITEMS / 3 * 2 + 50) begin
			hold_left <= 400;
			m_tready <= 0;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			m_tready <= 0;
		end else begin
			if (hold_left == 1)
				hold_left <= -1;
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_byte(input logic beg, input logic [7:0] b);
		int gap;
		if ($urandom_range(99) < send_idle) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= b;
		s_tuser <= beg;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		if (bytes_sent == N_ITEMS / 3) begin
			send_idle = 75;
			recv_idle = 9;
		end else if (bytes_sent == N_ITEMS / 3 * 2) begin
			send_idle = 0;
			recv_idle = 0;
			hold_go = 1;
		end
	endtask

	task automatic send_req();
		foreach (req_q[i])
			push_byte(i == 0, req_q[i]);
		req_q.delete();
	endtask

	task automatic add_byte(input logic [7:0] b);
		req_q = {req_q, b};
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function automatic logic [7:0] rand_tok();
		string t;
		t = "GETPOSTabcxyz019!#$%&'*+-.^_`|~";
		return t[$urandom_range(t.len() - 1)];
	endfunction

	function automatic string mixcase(input string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++)
			if (r[i] >= "a" && r[i] <= "z" && $urandom_range(1))
				r[i] = r[i] - 8'd32;
		return r;
	endfunction

	// well-formed request with random content, optionally damaged
	task automatic build_req();
		int n, blen, k;
		blen = 0;
		n = $urandom_range(1, 5);
		repeat (n) add_byte(rand_tok());
		add_byte(CH_SP);
		n = $urandom_range(1, 6);
		repeat (n) begin
			k = $urandom_range(33, 255);
			add_byte(k == 127 ? 8'h2F : k[7:0]);
		end
		add_str(" HTTP/");
		add_str($sformatf("%0d.%0d\r\n", $urandom_range(0, 12), $urandom_range(0, 12)));
		n = $urandom_range(0, 4);
		repeat (n) begin
			if ($urandom_range(2) == 0) begin
				blen = $urandom_range(0, 6);
				add_str({mixcase("content-length"), ": ", $sformatf("%0d", blen), "\r\n"});
			end else begin
				k = $urandom_range(1, 4);
				repeat (k) add_byte(rand_tok());
				add_str(": ");
				k = $urandom_range(0, 4);
				repeat (k) add_byte(8'($urandom_range(32, 126)));
				add_str("\r\n");
				if ($urandom_range(4) == 0)
					add_str(" \tcont\r\n");
			end
		end
		add_str("\r\n");
		repeat (blen) add_byte(8'($urandom_range(255)));
		k = $urandom_range(0, 2);
		repeat (k) add_byte(8'($urandom_range(255)));
		k = $urandom_range(99);
		if (k < 12) begin
			req_q[$urandom_range(req_q.size() - 1)] = 8'($urandom_range(255));
		end else if (k < 18) begin
			n = $urandom_range(1, req_q.size() - 1);
			while (req_q.size() > n) void'(req_q.pop_back());
		end else if (k < 22) begin
			req_q.delete();
			n = $urandom_range(1, 20);
			repeat (n) add_byte(8'($urandom_range(255)));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		add_str("GET / HTTP/1.1\r\n\r\nzz");
		send_req();
		add_str("GET /\x80\xff HTTP/99999.70000\r\nContent-Length: 3\r\n\r\n");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'h5A);
		send_req();
		add_str("P / HTTP/1.1\r\ncontent-LENGTH: 4294967296\r\n\r\n");
		send_req();
		add_str("P / HTTP/1.1\r\nContent-Length: 4294967295\r\n\r\nab");
		send_req();
		add_str("P / HTTP/1.1\r\nContent-Length: \r\n\r\n");
		send_req();
		add_str("P / HTTP/1.1\r\nContent-Length: 1x\r\nContent-Length: 2\r\n\r\n");
		send_req();
		add_str("P / HTTP/1.1\r\nContent-Length: 1\r\n  2\r\nA: b\tc\r\n");
		send_req();
		add_str("P / HTTP/1.1\r\nContent-Length: 1\r\n  2\r\n\r\n");
		repeat (12) add_byte(8'h7F);
		send_req();
		add_str("P / HTTP/1.1\r\n x\r\n\r\n");
		send_req();
		add_str("P / HTTP/1.1\r\n");
		repeat (33) add_str("A: 1\r\n");
		add_str("\r\n");
		send_req();
		add_str(" / HTTP/1.1\r\n");
		send_req();
		add_str("GET  HTTP/1.1\r\n");
		send_req();
		add_str("GET / HTTP/.1\r\n");
		send_req();
		while (bytes_sent < N_ITEMS) begin
			build_req();
			send_req();
		end
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+src
src/hrp_pkg.sv
src/hrp_front.sv
src/hrp_queue.sv
src/hrp_back.sv
src/http_request_header_parser.sv
tb/hrp_checker.sv
tb/tb.sv
